/* rtl/rtdlin_pkg.sv */
// ----------------------------------------------------------------------------
// rtdlin_pkg
// Shared widths, constants and the PT100 calibration table for the
// RTD table linearizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtdlin_pkg;

    // Field widths of the input and result items.
    localparam int RES_W  = 16;
    localparam int TEMP_W = 14;

    // Calibration table geometry: one entry per degree C from BASE_DEG upward.
    localparam int ROM_POINTS = 105;
    localparam int ROM_AW     = 7;
    localparam int ROM_W      = 14;
    localparam int BASE_DEG   = -42;

    // Interpolation scale (hundredths of a degree per segment).
    localparam int DEG_SCALE = 100;

    // The fraction (r - lo) * 100 / (hi - lo) never exceeds 100, so seven
    // quotient bits are enough.
    localparam int QUO_W = 7;
    localparam int NUM_W = ROM_W + QUO_W;

    // Resistances in centiohm, strictly increasing.
    localparam logic [ROM_W-1:0] ROM_TABLE [ROM_POINTS] = '{
        14'd8348,  14'd8388,  14'd8427,  14'd8467,  14'd8506,  14'd8546,  14'd8585,
        14'd8625,  14'd8664,  14'd8704,  14'd8743,  14'd8783,  14'd8822,  14'd8862,
        14'd8901,  14'd8940,  14'd8980,  14'd9019,  14'd9059,  14'd9098,  14'd9137,
        14'd9177,  14'd9216,  14'd9255,  14'd9295,  14'd9334,  14'd9373,  14'd9412,
        14'd9452,  14'd9491,  14'd9530,  14'd9569,  14'd9609,  14'd9648,  14'd9687,
        14'd9726,  14'd9765,  14'd9804,  14'd9844,  14'd9883,  14'd9922,  14'd9961,
        14'd10000, 14'd10039, 14'd10078, 14'd10117, 14'd10156, 14'd10195, 14'd10234,
        14'd10273, 14'd10312, 14'd10351, 14'd10390, 14'd10429, 14'd10468, 14'd10507,
        14'd10546, 14'd10585, 14'd10624, 14'd10663, 14'd10702, 14'd10740, 14'd10779,
        14'd10818, 14'd10857, 14'd10896, 14'd10935, 14'd10973, 14'd11012, 14'd11051,
        14'd11090, 14'd11129, 14'd11167, 14'd11206, 14'd11245, 14'd11283, 14'd11322,
        14'd11361, 14'd11400, 14'd11438, 14'd11477, 14'd11515, 14'd11554, 14'd11593,
        14'd11631, 14'd11670, 14'd11708, 14'd11747, 14'd11786, 14'd11824, 14'd11863,
        14'd11901, 14'd11940, 14'd11978, 14'd12017, 14'd12055, 14'd12094, 14'd12132,
        14'd12171, 14'd12209, 14'd12247, 14'd12286, 14'd12324, 14'd12362, 14'd12401
    };

    // Table lookup; addresses past the table read as zero.
    function automatic logic [ROM_W-1:0] rom_value(input logic [ROM_AW-1:0] addr);
        logic [ROM_W-1:0] val;
        val = '0;
        if (int'(addr) < ROM_POINTS) begin
            val = ROM_TABLE[addr];
        end
        return val;
    endfunction

endpackage

`default_nettype wire

/* rtl/rtd_table_linearizer_core.sv */
// ----------------------------------------------------------------------------
// rtd_table_linearizer_core
// PT100 linearizer: binary search over the calibration table for the
// bounding segment, then linear interpolation with a serial divider.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Signals                         | Contents
//  ---------+-----+---------------------------------+---------------------------
//  s_axis   | in  | tvalid, tready, tdata[15:0]     | resistance in centiohm
//  m_axis   | out | tvalid, tready, tdata[15:0],    | temperature in centidegree,
//           |     | tuser[0]                        | out-of-range flag
//
// An in-range item passes through an accept step, a binary search over the
// table for the bounding segment, a setup step, the restoring divider and a
// write-back step. An out-of-range item goes from accept straight to
// write-back. The input is not ready while an item is in flight; a finished
// result waits in the output register, so the next item is taken while the
// previous result is still unread. Write-back stalls only if the output
// register is still full. Reset is synchronous, active low.
//
`default_nettype none

module rtd_table_linearizer_core
    import rtdlin_pkg::*;
#(
    parameter int TABLE_ENTRIES = 105
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input stream: [15:0] resistance_centiohm
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [15:0]           i_s_axis_tdata,
    // Output stream: [13:0] temperature_centideg, [15:14] zero
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [15:0]                o_m_axis_tdata,
    // Output flag: [0] out_of_range
    output logic                       o_m_axis_tuser
);

    // Only the stored entries are usable.
    localparam int N_USED = (TABLE_ENTRIES < ROM_POINTS) ? TABLE_ENTRIES : ROM_POINTS;
    localparam int IDX_W  = (N_USED > 2) ? $clog2(N_USED) : 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_PREP   = 5'b00100,
        S_DIV    = 5'b01000,
        S_WB     = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [RES_W-1:0]    r_res, n_res;
    logic [IDX_W-1:0]    r_lo, n_lo;
    logic [IDX_W-1:0]    r_hi, n_hi;
    logic                r_oor, n_oor;
    logic                r_flat, n_flat;
    logic [NUM_W-1:0]    r_num, n_num;
    logic [NUM_W-1:0]    r_dsh, n_dsh;
    logic [QUO_W-1:0]    r_quo, n_quo;
    logic [2:0]          r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic [TEMP_W-1:0]   r_out_temp, n_out_temp;
    logic                r_out_oor, n_out_oor;

    logic                w_in_xfer;
    logic                w_out_xfer;
    logic [IDX_W:0]      w_mid_sum;
    logic [IDX_W-1:0]    w_mid;
    logic [IDX_W-1:0]    w_mid_p1;
    logic [IDX_W-1:0]    w_lo_p1;
    logic [ROM_W-1:0]    w_rom_mid;
    logic [ROM_W-1:0]    w_rom_lo;
    logic [ROM_W-1:0]    w_rom_hi;
    logic [ROM_W-1:0]    w_diff;
    logic [ROM_W-1:0]    w_den;
    logic                w_in_oor;
    logic                w_ge;
    logic signed [8:0]   w_deg;
    logic [TEMP_W-1:0]   w_deg_x;
    logic [TEMP_W-1:0]   w_frac;
    logic [TEMP_W-1:0]   w_temp;

    // Handshakes.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_xfer      = r_out_valid && i_m_axis_tready;

    // Range check against the first and last used entries.
    assign w_in_oor = (i_s_axis_tdata < RES_W'(rom_value(ROM_AW'(0)))) ||
                      (i_s_axis_tdata > RES_W'(rom_value(ROM_AW'(N_USED - 1))));

    // Search probe: upper bound of the middle segment.
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[IDX_W:1];
    assign w_mid_p1  = w_mid + IDX_W'(1);
    assign w_rom_mid = rom_value(ROM_AW'(w_mid_p1));
    assign w_ge      = (RES_W'(w_rom_mid) >= r_res);

    // Bounding entries of the selected segment.
    assign w_lo_p1  = r_lo + IDX_W'(1);
    assign w_rom_lo = rom_value(ROM_AW'(r_lo));
    assign w_rom_hi = rom_value(ROM_AW'(w_lo_p1));
    assign w_diff   = ROM_W'(r_res - RES_W'(w_rom_lo));
    assign w_den    = w_rom_hi - w_rom_lo;

    // Whole degrees plus the interpolated fraction.
    assign w_deg   = $signed(9'(r_lo)) + 9'(BASE_DEG);
    assign w_deg_x = TEMP_W'(w_deg);
    assign w_frac  = r_flat ? '0 : TEMP_W'(r_quo);
    assign w_temp  = TEMP_W'(w_deg_x * TEMP_W'(DEG_SCALE)) + w_frac;

    // Sequencer and datapath next values.
    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_oor       = r_oor;
        n_flat      = r_flat;
        n_num       = r_num;
        n_dsh       = r_dsh;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_temp  = r_out_temp;
        n_out_oor   = r_out_oor;

        if (w_out_xfer) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_res = i_s_axis_tdata;
                    n_lo  = '0;
                    n_hi  = IDX_W'(N_USED - 2);
                    n_oor = w_in_oor;
                    n_state = w_in_oor ? S_WB : S_SEARCH;
                end
            end
            S_SEARCH: begin
                // First segment whose upper entry reaches the resistance.
                if (r_lo == r_hi) begin
                    n_state = S_PREP;
                end else if (w_ge) begin
                    n_hi = w_mid;
                end else begin
                    n_lo = w_mid_p1;
                end
            end
            S_PREP: begin
                n_num  = NUM_W'({w_diff, 6'b0}) + NUM_W'({w_diff, 5'b0})
                       + NUM_W'({w_diff, 2'b0});
                n_dsh  = NUM_W'({w_den, 6'b0});
                n_flat = (w_den == '0);
                n_quo  = '0;
                n_cnt  = 3'd6;
                n_state = S_DIV;
            end
            S_DIV: begin
                // Restoring division, one quotient bit per cycle.
                if (r_num >= r_dsh) begin
                    n_num = r_num - r_dsh;
                    n_quo = {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_quo = {r_quo[QUO_W-2:0], 1'b0};
                end
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_temp  = r_oor ? '0 : w_temp;
                    n_out_oor   = r_oor;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state with reset, payload without.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_res      <= n_res;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_oor      <= n_oor;
        r_flat     <= n_flat;
        r_num      <= n_num;
        r_dsh      <= n_dsh;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_out_temp <= n_out_temp;
        r_out_oor  <= n_out_oor;
    end

    // Output register drives the result stream.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_temp};
    assign o_m_axis_tuser  = r_out_oor;

endmodule

`default_nettype wire

/* test/rtd_table_linearizer_core_test.sv */
// ----------------------------------------------------------------------------
// rtd_table_linearizer_core_test
// Self-checking bench for the PT100 table linearizer. Every resistance that
// the block accepts is converted to an expected temperature and range flag,
// and each result transfer is checked against the oldest one still pending.
// A directed set covers the table edges, exact table entries, the field
// extremes and the bit patterns of the input. It is followed by random
// resistances, a long receiver hold-off and a drain pause. Both sides insert
// random gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rtd_table_linearizer_core_test;
    import rtdlin_pkg::*;

    localparam int TABLE_ENTRIES  = 105;
    localparam int RANDOM_ITEMS   = 480;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;

    // Expected content of one result transfer.
    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     out_of_range;
    } t_reading;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [RES_W-1:0]  i_s_axis_tdata;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [15:0]       o_m_axis_tdata;
    logic              o_m_axis_tuser;

    t_reading expected_readings[$];

    int items_sent;
    int readings_checked;
    int out_of_range_seen;
    int mismatches;
    int tx_calm_left;
    int hold_off_left;

    rtd_table_linearizer_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        // [15:0] resistance_centiohm
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        // [13:0] temperature_centideg, [15:14] zero
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        // [0] out_of_range
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Converts a resistance to the temperature of the first enclosing segment.
    function automatic t_reading predict_reading(input logic [RES_W-1:0] resistance);
        t_reading result;
        int       used;
        int       rval;
        int       lo;
        int       hi;
        int       frac;
        int       temp;
        bit       found;
        result = '0;
        found  = 1'b0;
        rval   = int'(resistance);
        used   = (TABLE_ENTRIES > ROM_POINTS) ? ROM_POINTS : TABLE_ENTRIES;
        if (used >= 2 && rval >= int'(ROM_TABLE[0]) && rval <= int'(ROM_TABLE[used-1])) begin
            for (int seg = 0; seg + 1 < used && !found; seg++) begin
                lo = int'(ROM_TABLE[seg]);
                hi = int'(ROM_TABLE[seg+1]);
                if (rval >= lo && rval <= hi) begin
                    frac  = (hi > lo) ? ((rval - lo) * DEG_SCALE) / (hi - lo) : 0;
                    temp  = (BASE_DEG + seg) * DEG_SCALE + frac;
                    found = 1'b1;
                end
            end
        end
        if (found) begin
            result.temperature = temp[TEMP_W-1:0];
        end else begin
            result.out_of_range = 1'b1;
        end
        return result;
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 4);
        if (roll < 98) return $urandom_range(5, 20);
        return $urandom_range(40, 120);
    endfunction

    // Offers one resistance and returns at the falling edge after its transfer.
    task automatic send_resistance(input logic [RES_W-1:0] resistance);
        int gap;
        if (tx_calm_left > 0) begin
            gap = 0;
            tx_calm_left--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 99) < 2) tx_calm_left = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = resistance;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_readings.push_back(predict_reading(resistance));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Random resistance, weighted toward the table span and its edges.
    function automatic logic [RES_W-1:0] random_resistance();
        int roll;
        int idx;
        roll = $urandom_range(0, 99);
        if (roll < 60) return RES_W'($urandom_range(ROM_TABLE[0], ROM_TABLE[ROM_POINTS-1]));
        if (roll < 75) begin
            idx = $urandom_range(0, ROM_POINTS - 1);
            return RES_W'(int'(ROM_TABLE[idx]) + $urandom_range(0, 2) - 1);
        end
        if (roll < 85) return RES_W'($urandom_range(ROM_TABLE[0] - 60, ROM_TABLE[0]));
        if (roll < 92) return RES_W'($urandom_range(ROM_TABLE[ROM_POINTS-1],
                                                   ROM_TABLE[ROM_POINTS-1] + 60));
        return RES_W'($urandom_range(0, 65535));
    endfunction

    task automatic wait_for_drain();
        while (expected_readings.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Table edges, exact entries, field extremes and alternating bit patterns.
    task automatic test_directed_corners();
        logic [RES_W-1:0] corners [22] = '{
            16'd0,     16'd65535, 16'd8347,  16'd8348,  16'd8349,  16'd8368,
            16'd8388,  16'd10000, 16'd10019, 16'd10739, 16'd10740, 16'd12361,
            16'd12362, 16'd12400, 16'd12401, 16'd12402, 16'd16383, 16'd16384,
            16'd21845, 16'd43690, 16'd32767, 16'd32768
        };
        foreach (corners[k]) send_resistance(corners[k]);
    endtask

    task automatic test_random_resistances();
        repeat (RANDOM_ITEMS) send_resistance(random_resistance());
    endtask

    // The receiver holds off while the sender keeps offering back to back.
    task automatic test_output_backpressure();
        @(posedge i_clk);
        hold_off_left = HOLD_OFF_LEN;
        @(negedge i_clk);
        tx_calm_left = 30;
        repeat (30) send_resistance(random_resistance());
    endtask

    // The sender stops until every pending result has been read.
    task automatic test_drain_pause();
        repeat (4) begin
            repeat (8) send_resistance(random_resistance());
            i_s_axis_tvalid = 1'b0;
            wait_for_drain();
        end
    endtask

    // Receiver: random stalls, quiet stretches and the requested hold-off.
    initial begin
        int rx_stall_left;
        int rx_calm_left;
        rx_stall_left   = 0;
        rx_calm_left    = 0;
        hold_off_left   = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                i_m_axis_tready = 1'b0;
                hold_off_left--;
            end else if (rx_stall_left > 0) begin
                i_m_axis_tready = 1'b0;
                rx_stall_left--;
            end else begin
                i_m_axis_tready = 1'b1;
                if (rx_calm_left > 0) begin
                    rx_calm_left--;
                end else if ($urandom_range(0, 99) < 3) begin
                    rx_calm_left = $urandom_range(50, 200);
                end else if ($urandom_range(0, 99) < 30) begin
                    rx_stall_left = pick_gap();
                end
            end
        end
    end

    // Result checker: each transfer against the oldest pending expectation.
    always @(posedge i_clk) begin : check_results
        t_reading want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result tdata=%h tuser=%b",
                             $time, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                want = expected_readings.pop_front();
                readings_checked++;
                if (want.out_of_range) out_of_range_seen++;
                if (o_m_axis_tdata[TEMP_W-1:0] !== want.temperature ||
                    o_m_axis_tdata[15:TEMP_W] !== '0 ||
                    o_m_axis_tuser !== want.out_of_range) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch temp exp %0d got %0d (tdata %h), oor exp %b got %b",
                                 $time, want.temperature,
                                 $signed(o_m_axis_tdata[TEMP_W-1:0]), o_m_axis_tdata,
                                 want.out_of_range, o_m_axis_tuser);
                end
            end
        end
    end

    // Watchdog: ends the run after a long stretch without any transfer.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("rtd_table_linearizer_core_test failed");
        $finish;
    end

    // Main sequence.
    initial begin
        items_sent        = 0;
        readings_checked  = 0;
        out_of_range_seen = 0;
        mismatches        = 0;
        tx_calm_left      = 0;
        i_rst_n           = 1'b0;
        i_s_axis_tvalid   = 1'b0;
        i_s_axis_tdata    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_corners();
        test_random_resistances();
        test_output_backpressure();
        test_drain_pause();
        test_random_resistances();

        i_s_axis_tvalid = 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d resistances, checked %0d results (%0d out of range).",
                 items_sent, readings_checked, out_of_range_seen);
        $display("Covered table edges, exact entries, output backpressure and drain pauses.");
        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("rtd_table_linearizer_core_test passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_readings.size());
            $display("rtd_table_linearizer_core_test failed");
        end
        $finish;
    end

endmodule
